[src/gncs_pkg.sv]
// Shared widths, register indexes and sequencer states of the nearest-candidate search unit.
`default_nettype none

package gncs_pkg;

	localparam int POS_W    = 24;  // Q8.16 position
	localparam int VAR_W    = 20;  // Q4.16 variance
	localparam int TRACE_W  = 21;  // var_xx + var_yy
	localparam int GATE_W   = 23;  // Q7.16 gate
	localparam int ID_W     = 16;  // id field on the ports
	localparam int SLOT_W   = 4;   // slot field on the ports
	localparam int SLOT_EXT_W = 9; // slot widened for the depth check
	localparam int HALF_W   = 25;  // operand width of the shared multiplier
	localparam int PROD_W   = 2 * HALF_W;
	localparam int DIST_W   = 50;  // squared distance, Q18.32
	localparam int CROSS_W  = 72;  // squared distance times trace
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_GATE_NORMAL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GATE_UC     = 1'd1;

	localparam logic [GATE_W-1:0] GATE_NORMAL_RST = 23'd32768;
	localparam logic [GATE_W-1:0] GATE_UC_RST     = 23'd131072;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_DIFF,
		ST_SQX,
		ST_SQY,
		ST_SQZ,
		ST_DSUM,
		ST_LLO,
		ST_LHI,
		ST_RLO,
		ST_RHI,
		ST_CMP,
		ST_GATE,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

[src/gated_nearest_candidate_search_unit.sv]
// Top level of the gated nearest-candidate search unit: table, sequencer and shared multiplier.
//
// A command word is taken when start is high and busy is low. A write word
// (cmd 0) loads one table slot in that cycle and produces no result; busy stays
// low, so another word may follow at once. A query word (cmd 1) scans every
// slot in order with one shared 25x25 multiplier and reports one result: done
// is high for exactly one cycle with found and match_id, and the receiver
// cannot stall it. A query skips dead slots and live slots whose flag differs
// from the query; the first matching slot takes three squares through the
// multiplier, and every later matching slot takes the three squares and four
// partial cross products. The gate square and the result follow the last
// slot. Busy drops in the cycle that done is shown, so the next word may be
// accepted then. Cost is compared exactly as D_new * t_best < D_best * t_new
// with the trace clamped to one LSB; on a tie the lower slot keeps the win.
// Gate registers may be written at any time the unit is idle.
`default_nettype none

module gated_nearest_candidate_search_unit #(
	parameter int TABLE_DEPTH = 16,
	parameter int ID_BITS     = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// command channel
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                cmd,
	input  wire logic [gncs_pkg::SLOT_W-1:0]         slot,
	input  wire logic [gncs_pkg::ID_W-1:0]           entry_id,
	input  wire logic                                entry_valid,
	input  wire logic signed [gncs_pkg::POS_W-1:0]   pos_x,
	input  wire logic signed [gncs_pkg::POS_W-1:0]   pos_y,
	input  wire logic signed [gncs_pkg::POS_W-1:0]   pos_z,
	input  wire logic [gncs_pkg::VAR_W-1:0]          var_xx,
	input  wire logic [gncs_pkg::VAR_W-1:0]          var_yy,
	input  wire logic                                under_constrained,
	// result channel
	output logic                                     done,
	output logic                                     found,
	output logic [gncs_pkg::ID_W-1:0]                match_id,
	// register write port
	input  wire logic                                cfg_we,
	input  wire logic [gncs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [gncs_pkg::GATE_W-1:0]         cfg_wdata
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
	localparam int HW = gncs_pkg::HALF_W;

	typedef struct packed {
		logic [ID_BITS-1:0]                     id;
		logic signed [gncs_pkg::POS_W-1:0]      x;
		logic signed [gncs_pkg::POS_W-1:0]      y;
		logic signed [gncs_pkg::POS_W-1:0]      z;
		logic [gncs_pkg::TRACE_W-1:0]           trace;
		logic                                   flag;
	} entry_t;

	// ------------------------------------------------------------------
	// Gate registers
	// ------------------------------------------------------------------
	logic [gncs_pkg::GATE_W-1:0] gate_n_q;
	logic [gncs_pkg::GATE_W-1:0] gate_uc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_n_q  <= gncs_pkg::GATE_NORMAL_RST;
			gate_uc_q <= gncs_pkg::GATE_UC_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gncs_pkg::REG_GATE_NORMAL: gate_n_q  <= cfg_wdata;
				gncs_pkg::REG_GATE_UC:     gate_uc_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Command accept and table write
	// ------------------------------------------------------------------
	gncs_pkg::state_t state_q, state_d;

	logic accept;
	logic wr_en;
	logic [gncs_pkg::SLOT_EXT_W-1:0] slot_ext;
	logic [IDX_W-1:0] wr_idx;
	entry_t wr_entry;

	assign busy     = (state_q != gncs_pkg::ST_IDLE);
	assign accept   = start && !busy;
	assign slot_ext = gncs_pkg::SLOT_EXT_W'(slot);
	assign wr_idx   = slot_ext[IDX_W-1:0];
	// Drop writes to slots beyond the table.
	assign wr_en    = accept && !cmd &&
		(slot_ext < gncs_pkg::SLOT_EXT_W'(TABLE_DEPTH));

	always_comb begin
		wr_entry.id    = ID_BITS'(entry_id);
		wr_entry.x     = pos_x;
		wr_entry.y     = pos_y;
		wr_entry.z     = pos_z;
		wr_entry.trace = gncs_pkg::TRACE_W'(var_xx) + gncs_pkg::TRACE_W'(var_yy);
		wr_entry.flag  = under_constrained;
	end

	entry_t mem_q [TABLE_DEPTH];
	entry_t rd_q;
	logic [IDX_W-1:0] idx_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_entry;
		end
		rd_q <= mem_q[idx_q];
	end

	// Live bits: the only part of the table that reset clears.
	logic [TABLE_DEPTH-1:0] live_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
		end else if (wr_en) begin
			live_q[wr_idx] <= entry_valid;
		end
	end

	// ------------------------------------------------------------------
	// Query registers and datapath
	// ------------------------------------------------------------------
	logic signed [gncs_pkg::POS_W-1:0] qx_q, qy_q, qz_q;
	logic                              qflag_q;
	logic [HW-1:0]                     ax_q, ay_q, az_q;
	logic [gncs_pkg::TRACE_W-1:0]      tn_q;
	logic [ID_BITS-1:0]                idn_q;
	logic [gncs_pkg::DIST_W-1:0]       acc_q, d_q;
	logic [gncs_pkg::CROSS_W-1:0]      lhs_q, rhs_q;
	logic [gncs_pkg::PROD_W-1:0]       prod_q;

	logic                              have_q;
	logic [gncs_pkg::DIST_W-1:0]       best_d_q;
	logic [gncs_pkg::TRACE_W-1:0]      best_t_q;
	logic [ID_BITS-1:0]                best_id_q;

	logic [HW-1:0] mul_a, mul_b;
	logic [gncs_pkg::PROD_W-1:0] mul_p;
	logic [HW-1:0] dx, dy, dz;
	logic [gncs_pkg::DIST_W-1:0] d_full;
	logic [gncs_pkg::CROSS_W-1:0] rhs_full;
	logic cmp_less;
	logic slot_done;
	logic take_first;
	logic take_better;
	logic gate_pass;

	// Signed differences, one bit wider than the positions.
	assign dx = {qx_q[gncs_pkg::POS_W-1], qx_q} - {rd_q.x[gncs_pkg::POS_W-1], rd_q.x};
	assign dy = {qy_q[gncs_pkg::POS_W-1], qy_q} - {rd_q.y[gncs_pkg::POS_W-1], rd_q.y};
	assign dz = {qz_q[gncs_pkg::POS_W-1], qz_q} - {rd_q.z[gncs_pkg::POS_W-1], rd_q.z};

	assign d_full   = acc_q + prod_q;
	assign rhs_full = rhs_q + (gncs_pkg::CROSS_W'(prod_q) << HW);
	assign cmp_less = (lhs_q < rhs_full);
	assign gate_pass = have_q && (best_d_q < prod_q);

	assign take_first  = (state_q == gncs_pkg::ST_DSUM) && !have_q;
	assign take_better = (state_q == gncs_pkg::ST_CMP) && cmp_less;

	// Shared multiplier: operands by sequencer step, product registered.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			gncs_pkg::ST_SQX: begin
				mul_a = ax_q;
				mul_b = ax_q;
			end
			gncs_pkg::ST_SQY: begin
				mul_a = ay_q;
				mul_b = ay_q;
			end
			gncs_pkg::ST_SQZ: begin
				mul_a = az_q;
				mul_b = az_q;
			end
			gncs_pkg::ST_LLO: begin
				mul_a = d_q[HW-1:0];
				mul_b = HW'(best_t_q);
			end
			gncs_pkg::ST_LHI: begin
				mul_a = d_q[gncs_pkg::DIST_W-1:HW];
				mul_b = HW'(best_t_q);
			end
			gncs_pkg::ST_RLO: begin
				mul_a = best_d_q[HW-1:0];
				mul_b = HW'(tn_q);
			end
			gncs_pkg::ST_RHI: begin
				mul_a = best_d_q[gncs_pkg::DIST_W-1:HW];
				mul_b = HW'(tn_q);
			end
			gncs_pkg::ST_GATE: begin
				mul_a = HW'(qflag_q ? gate_uc_q : gate_n_q);
				mul_b = HW'(qflag_q ? gate_uc_q : gate_n_q);
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Payload registers: no reset.
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (accept && cmd) begin
			qx_q    <= pos_x;
			qy_q    <= pos_y;
			qz_q    <= pos_z;
			qflag_q <= under_constrained;
		end
		if (state_q == gncs_pkg::ST_DIFF) begin
			// Take magnitudes; the most negative difference maps to 2^24 - 1 unsigned.
			ax_q  <= dx[HW-1] ? -dx : dx;
			ay_q  <= dy[HW-1] ? -dy : dy;
			az_q  <= dz[HW-1] ? -dz : dz;
			tn_q  <= (rd_q.trace == '0) ? gncs_pkg::TRACE_W'(1) : rd_q.trace;
			idn_q <= rd_q.id;
		end
		if (state_q == gncs_pkg::ST_SQY) acc_q <= prod_q;
		if (state_q == gncs_pkg::ST_SQZ) acc_q <= d_full;
		if (state_q == gncs_pkg::ST_DSUM) d_q <= d_full;
		if (state_q == gncs_pkg::ST_LHI) lhs_q <= gncs_pkg::CROSS_W'(prod_q);
		if (state_q == gncs_pkg::ST_RLO) begin
			lhs_q <= lhs_q + (gncs_pkg::CROSS_W'(prod_q) << HW);
		end
		if (state_q == gncs_pkg::ST_RHI) rhs_q <= gncs_pkg::CROSS_W'(prod_q);
		if (take_first) begin
			best_d_q  <= d_full;
			best_t_q  <= tn_q;
			best_id_q <= idn_q;
		end else if (take_better) begin
			best_d_q  <= d_q;
			best_t_q  <= tn_q;
			best_id_q <= idn_q;
		end
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gncs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		slot_done = 1'b0;
		unique case (state_q)
			gncs_pkg::ST_IDLE: begin
				if (accept && cmd) state_d = gncs_pkg::ST_READ;
			end
			gncs_pkg::ST_READ: begin
				// Skip dead slots without waiting for the table data.
				if (live_q[idx_q]) state_d = gncs_pkg::ST_DIFF;
				else slot_done = 1'b1;
			end
			gncs_pkg::ST_DIFF: begin
				if (rd_q.flag == qflag_q) state_d = gncs_pkg::ST_SQX;
				else slot_done = 1'b1;
			end
			gncs_pkg::ST_SQX: state_d = gncs_pkg::ST_SQY;
			gncs_pkg::ST_SQY: state_d = gncs_pkg::ST_SQZ;
			gncs_pkg::ST_SQZ: state_d = gncs_pkg::ST_DSUM;
			gncs_pkg::ST_DSUM: begin
				// First match wins outright; no cross products needed.
				if (have_q) state_d = gncs_pkg::ST_LLO;
				else slot_done = 1'b1;
			end
			gncs_pkg::ST_LLO: state_d = gncs_pkg::ST_LHI;
			gncs_pkg::ST_LHI: state_d = gncs_pkg::ST_RLO;
			gncs_pkg::ST_RLO: state_d = gncs_pkg::ST_RHI;
			gncs_pkg::ST_RHI: state_d = gncs_pkg::ST_CMP;
			gncs_pkg::ST_CMP: slot_done = 1'b1;
			gncs_pkg::ST_GATE: state_d = gncs_pkg::ST_FIN;
			gncs_pkg::ST_FIN: state_d = gncs_pkg::ST_IDLE;
			default: state_d = gncs_pkg::ST_IDLE;
		endcase
		if (slot_done) begin
			state_d = (idx_q == LAST_IDX) ? gncs_pkg::ST_GATE : gncs_pkg::ST_READ;
		end
	end

	// Slot counter and candidate flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			have_q <= 1'b0;
		end else begin
			if (accept && cmd) begin
				idx_q  <= '0;
				have_q <= 1'b0;
			end else begin
				if (slot_done) idx_q <= idx_q + IDX_W'(1);
				if (take_first) have_q <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result register: one-cycle strobe
	// ------------------------------------------------------------------
	logic done_q;
	logic found_q;
	logic [gncs_pkg::ID_W-1:0] match_id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == gncs_pkg::ST_FIN);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == gncs_pkg::ST_FIN) begin
			found_q    <= gate_pass;
			match_id_q <= gate_pass ? gncs_pkg::ID_W'(best_id_q) : '0;
		end
	end

	assign done     = done_q;
	assign found    = found_q;
	assign match_id = match_id_q;

endmodule

`default_nettype wire
